FILE: sv/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants of the line and rectangle-outline rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none
package dda_pkg;
  localparam int unsigned DefCoordBits = 12;
  localparam int unsigned DefFracBits  = 16;
  localparam int unsigned DefColorBits = 16;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_LINE = 2'd1;
  localparam logic [1:0] OP_RECT = 2'd2;

  // Divider request: divides num << FRAC_BITS by den with rounding to nearest.
  typedef struct packed {
    logic start;
    logic neg;
  } div_ctl_t;
endpackage
`default_nettype wire

FILE: sv/dda_div.sv
// ----------------------------------------------------------------------------
// dda_div
// Restoring divider, one quotient bit per cycle, for the slope of a line.
// Computes round(n*2^F / d) as floor((n*2^(F+1) + d) / (2d)).
// ----------------------------------------------------------------------------
`default_nettype none
module dda_div
  import dda_pkg::*;
#(
  parameter int unsigned COORD_BITS = DefCoordBits,
  parameter int unsigned FRAC_BITS  = DefFracBits
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire div_ctl_t               ctl_i,
  input  wire logic [COORD_BITS:0]    num_i,   // magnitude
  input  wire logic [COORD_BITS:0]    den_i,   // positive
  output logic                        done_o,
  output logic signed [FRAC_BITS+1:0] quot_o
);
  // dividend = n*2^(F+1) + d, divisor = 2d; quotient <= 2^F
  localparam int unsigned DW = COORD_BITS + FRAC_BITS + 3;
  localparam int unsigned RW = COORD_BITS + 3;
  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] dvd_q, dvd_d;
  logic [RW-1:0] rem_q, rem_d, dvs_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d, neg_q;
  logic [RW-1:0] trial;
  logic [RW:0]   diff;

  assign trial = {rem_q[RW-2:0], dvd_q[DW-1]};
  assign diff  = {1'b0, trial} - {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_o = 1'b0;
    if (ctl_i.start) begin
      dvd_d = (DW'(num_i) << (FRAC_BITS + 1)) + DW'(den_i);
      rem_d = '0;
      cnt_d = CW'(DW);
      run_d = 1'b1;
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_o = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
        if (!diff[RW]) begin
          rem_d = diff[RW-1:0];
          dvd_d = {dvd_q[DW-2:0], 1'b1};
        end else begin
          rem_d = trial;
          dvd_d = {dvd_q[DW-2:0], 1'b0};
        end
      end
    end
  end

  assign quot_o = neg_q ? -$signed(dvd_q[FRAC_BITS+1:0]) : $signed(dvd_q[FRAC_BITS+1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (ctl_i.start) begin
      dvs_q <= {den_i, 1'b0};
      neg_q <= ctl_i.neg;
    end
  end
endmodule
`default_nettype wire

FILE: sv/dda_line_rect_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rect_rasterizer
// Line and rectangle-outline pixel generator with a fixed-point DDA.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                        | tuser/tlast
//  s_axis  | in  | x_start, y_start, x_end, y_end, color    | tuser = op
//  m_axis  | out | pixel_x, pixel_y, pixel_color            | tlast = last_pixel
//
// A draw command passes through LOAD for lines along an axis, and through
// LOAD and then DIV, waiting on the bit-serial slope divider, for sloped
// lines; rectangle segments reload through the same path.
// A tick moves RUN to EMIT, where the pixel is formed into the output
// register once it is empty; it holds a pixel while m_axis stalls.
// Reset is asynchronous, active low, and leaves the block idle.
`default_nettype none
module dda_line_rect_rasterizer
  import dda_pkg::*;
#(
  parameter int unsigned COORD_BITS = DefCoordBits,
  parameter int unsigned FRAC_BITS  = DefFracBits,
  parameter int unsigned COLOR_BITS = DefColorBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // x_start, y_start, x_end, y_end, color, zero fill
  input  wire logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic [1:0] s_axis_tuser,  // op
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // pixel_x, pixel_y, pixel_color, zero fill
  output logic [((2*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic      m_axis_tlast   // last_pixel
);
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned AW = CB + FRAC_BITS + 1;
  localparam int unsigned OW = ((2*CB+COLOR_BITS+7)/8)*8;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_RUN  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] st_q, st_d;
  logic       rect_q;
  logic [1:0] seg_q, seg_d;
  logic signed [CB-1:0] c0_q, c1_q, c2_q, c3_q;
  logic [COLOR_BITS-1:0] col_q;
  logic       xmaj_q, xmaj_d;
  logic signed [CB-1:0] mpos_q, mpos_d;
  logic [CB:0] mrem_q, mrem_d;
  logic signed [AW-1:0] acc_q, acc_d;
  logic signed [FRAC_BITS+1:0] slope_q, slope_d;
  logic       ovalid_q, olast_q;
  logic [OW-1:0] odata_q;
  logic       emit;

  // current segment endpoints
  logic signed [CB-1:0] xa, ya, xb, yb, sxa, sya;
  always_comb begin
    xa = c0_q; ya = c1_q; xb = c2_q; yb = c3_q;
    if (rect_q) begin
      unique case (seg_q)
        2'd0: begin xa = c0_q; ya = c1_q; xb = c2_q; yb = c1_q; end
        2'd1: begin xa = c0_q; ya = c3_q; xb = c2_q; yb = c3_q; end
        2'd2: begin xa = c0_q; ya = c1_q; xb = c0_q; yb = c3_q; end
        default: begin xa = c2_q; ya = c1_q; xb = c2_q; yb = c3_q; end
      endcase
    end
  end

  logic signed [CB:0] dx, dy;
  logic [CB:0] adx, ady;
  logic swap, xm, axis_line;
  assign dx  = {xb[CB-1], xb} - {xa[CB-1], xa};
  assign dy  = {yb[CB-1], yb} - {ya[CB-1], ya};
  assign adx = dx[CB] ? -dx : dx;
  assign ady = dy[CB] ? -dy : dy;
  assign axis_line = (dx == '0) || (dy == '0);
  assign xm   = (dx == '0) ? 1'b0 : (dy == '0) ? 1'b1 : (adx > ady);
  assign swap = xm ? dx[CB] : dy[CB];
  assign sxa  = swap ? xb : xa;
  assign sya  = swap ? yb : ya;

  div_ctl_t dctl;
  logic     ddone;
  logic signed [FRAC_BITS+1:0] dquot;
  assign dctl.start = (st_q == ST_LOAD) && !axis_line;
  assign dctl.neg   = xm ? (dy[CB] ^ dx[CB]) : (dx[CB] ^ dy[CB]);

  dda_div #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .ctl_i(dctl),
    .num_i(xm ? ady : adx), .den_i(xm ? adx : ady),
    .done_o(ddone), .quot_o(dquot)
  );

  logic signed [CB-1:0] minor;
  assign minor = acc_q[CB+FRAC_BITS-1:FRAC_BITS];  // arithmetic floor
  assign emit  = (st_q == ST_EMIT) && !ovalid_q;

  assign s_axis_tready = (st_q == ST_IDLE) || (st_q == ST_RUN);

  logic acc_in;
  assign acc_in = s_axis_tvalid && s_axis_tready;

  always_comb begin
    st_d = st_q; seg_d = seg_q;
    xmaj_d = xmaj_q; mpos_d = mpos_q; mrem_d = mrem_q;
    acc_d = acc_q; slope_d = slope_q;
    unique case (st_q)
      ST_IDLE: begin
        if (acc_in && (s_axis_tuser == OP_LINE || s_axis_tuser == OP_RECT)) begin
          st_d = ST_LOAD; seg_d = '0;
        end
      end
      ST_LOAD: begin
        xmaj_d  = xm;
        slope_d = '0;
        if (dx == '0) begin
          mpos_d = (ya < yb) ? ya : yb; mrem_d = ady;
        end else if (dy == '0) begin
          mpos_d = (xa < xb) ? xa : xb; mrem_d = adx;
        end else begin
          mpos_d = xm ? sxa : sya; mrem_d = xm ? adx : ady;
        end
        acc_d = AW'($signed({(xm ? sya : sxa), {FRAC_BITS{1'b0}}}));
        st_d  = axis_line ? ST_RUN : ST_DIV;
      end
      ST_DIV: begin
        if (ddone) begin
          slope_d = dquot; st_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (acc_in && s_axis_tuser == OP_TICK) st_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit) begin
          if (mrem_q != '0) begin
            mrem_d = mrem_q - 1'b1;
            mpos_d = mpos_q + 1'b1;
            acc_d  = acc_q + AW'(slope_q);
            st_d   = ST_RUN;
          end else if (rect_q && seg_q != 2'd3) begin
            seg_d = seg_q + 1'b1; st_d = ST_LOAD;
          end else begin
            st_d = ST_IDLE;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; seg_q <= '0; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d; seg_q <= seg_d;
      if (emit) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    xmaj_q <= xmaj_d; mpos_q <= mpos_d; mrem_q <= mrem_d;
    acc_q <= acc_d; slope_q <= slope_d;
    if (st_q == ST_IDLE && acc_in) begin
      c0_q   <= s_axis_tdata[CB-1:0];
      c1_q   <= s_axis_tdata[2*CB-1:CB];
      c2_q   <= s_axis_tdata[3*CB-1:2*CB];
      c3_q   <= s_axis_tdata[4*CB-1:3*CB];
      col_q  <= s_axis_tdata[4*CB+COLOR_BITS-1:4*CB];
      rect_q <= (s_axis_tuser == OP_RECT);
    end
    if (emit) begin
      odata_q <= OW'({col_q, (xmaj_q ? minor : mpos_q), (xmaj_q ? mpos_q : minor)});
      olast_q <= (mrem_q == '0) && !(rect_q && seg_q != 2'd3);
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;
endmodule
`default_nettype wire

FILE: sv/dda_checker.sv
// ----------------------------------------------------------------------------
// dda_checker
// Port-level checks of the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module dda_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic m_axis_tlast
);
  // a pixel held on a stall keeps its valid
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("valid dropped");
  // after a handshake no second pixel appears the next cycle
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid) else $error("pixel repeated");
  // with no pixel pending, none appears in the cycle after an accepted input
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("pixel too early");
  // the last flag stays put while a pixel is held
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tlast))
    else $error("last changed on stall");
endmodule

bind dda_line_rect_rasterizer dda_checker u_dda_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tlast
);
`default_nettype wire
